/* sv/src_pkg.sv */
// ----------------------------------------------------------------------------
// src_pkg
// Shared constants for the segment rectangle clipper.
// ----------------------------------------------------------------------------
package src_pkg;
  localparam logic [3:0] OC_LEFT   = 4'h1;
  localparam logic [3:0] OC_RIGHT  = 4'h2;
  localparam logic [3:0] OC_BOTTOM = 4'h4;
  localparam logic [3:0] OC_TOP    = 4'h8;
  localparam int PASS_LIMIT = 8;

  localparam logic [1:0] REG_MIN_X = 2'd0;
  localparam logic [1:0] REG_MAX_X = 2'd1;
  localparam logic [1:0] REG_MIN_Y = 2'd2;
  localparam logic [1:0] REG_MAX_Y = 2'd3;
endpackage

/* sv/segment_rectangle_clipper_core.sv */
// ----------------------------------------------------------------------------
// segment_rectangle_clipper_core
// Cohen-Sutherland segment clipper against a configured rectangle.
// ----------------------------------------------------------------------------
// One segment at a time. Each clip pass runs one interpolation through the
// shared bit-serial multiply/divide unit; up to eight passes. Input stall
// is held high from acceptance until the result transfers.
module segment_rectangle_clipper_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    point_count,
  output logic signed [COORD_WIDTH-1:0] first_x,
  output logic signed [COORD_WIDTH-1:0] first_y,
  output logic signed [COORD_WIDTH-1:0] second_x,
  output logic signed [COORD_WIDTH-1:0] second_y,
  output logic                          accepted
);
  import src_pkg::*;
  localparam int W = COORD_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic signed [W-1:0] rmin_x, rmax_x, rmin_y, rmax_y;
  logic signed [W-1:0] x0, y0, x1, y1;
  logic signed [W-1:0] ex, ey;
  logic [2:0] state;
  logic [3:0] passes;
  logic [3:0] c0, c1, co;
  logic       mv0;
  logic       use_y;
  logic       md_start, md_done;
  logic signed [W-1:0] md_res;
  logic signed [W-1:0] ma0, edge_v;
  logic signed [W:0]   mda, mde, mdb;
  logic signed [W-1:0] nx, ny;
  logic [3:0] nc;

  function automatic logic [3:0] ocode(input logic signed [W-1:0] x,
      input logic signed [W-1:0] y, input logic signed [W-1:0] lx,
      input logic signed [W-1:0] hx, input logic signed [W-1:0] ly,
      input logic signed [W-1:0] hy);
    logic [3:0] c;
    c = '0;
    if (x < lx) c = c | OC_LEFT;
    else if (x > hx) c = c | OC_RIGHT;
    if (y < ly) c = c | OC_BOTTOM;
    else if (y > hy) c = c | OC_TOP;
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rmin_x <= '0; rmax_x <= '0; rmin_y <= '0; rmax_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_X: rmin_x <= cfg_data;
        REG_MAX_X: rmax_x <= cfg_data;
        REG_MIN_Y: rmin_y <= cfg_data;
        REG_MAX_Y: rmax_y <= cfg_data;
        default: ;
      endcase
    end
  end

  assign c0 = ocode(x0, y0, rmin_x, rmax_x, rmin_y, rmax_y);
  assign c1 = ocode(x1, y1, rmin_x, rmax_x, rmin_y, rmax_y);
  assign co = (c0 != '0) ? c0 : c1;

  always_comb begin
    use_y  = 1'b1;
    edge_v = rmin_x;
    if ((co & OC_TOP) != '0) edge_v = rmax_y;
    else if ((co & OC_BOTTOM) != '0) edge_v = rmin_y;
    else if ((co & OC_RIGHT) != '0) begin use_y = 1'b0; edge_v = rmax_x; end
    else use_y = 1'b0;
    if (use_y) begin
      ma0 = x0;
      mda = (W + 1)'(x1) - (W + 1)'(x0);
      mde = (W + 1)'(edge_v) - (W + 1)'(y0);
      mdb = (W + 1)'(y1) - (W + 1)'(y0);
    end else begin
      ma0 = y0;
      mda = (W + 1)'(y1) - (W + 1)'(y0);
      mde = (W + 1)'(edge_v) - (W + 1)'(x0);
      mdb = (W + 1)'(x1) - (W + 1)'(x0);
    end
  end

  assign md_start = (state == S_DEC) && (c0 | c1) != '0 && (c0 & c1) == '0
                    && passes != 4'(PASS_LIMIT);

  src_muldiv #(.W(W)) u_md (
    .clk(clk), .rst(rst), .start(md_start), .a0(ma0), .da(mda), .de(mde),
    .db(mdb), .done(md_done), .res(md_res)
  );

  assign nx = use_y ? md_res : ex;
  assign ny = use_y ? ey : md_res;
  assign nc = ocode(nx, ny, rmin_x, rmax_x, rmin_y, rmax_y);

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      passes    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x0 <= seg_start_x; y0 <= seg_start_y;
            x1 <= seg_end_x;   y1 <= seg_end_y;
            passes      <= '0;
            point_count <= '0;
            first_x <= '0; first_y <= '0; second_x <= '0; second_y <= '0;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if ((c0 | c1) == '0) begin
            accepted <= 1'b1; out_valid <= 1'b1; state <= S_OUT;
          end else if ((c0 & c1) != '0 || passes == 4'(PASS_LIMIT)) begin
            accepted <= 1'b0; point_count <= '0;
            first_x <= '0; first_y <= '0; second_x <= '0; second_y <= '0;
            out_valid <= 1'b1; state <= S_OUT;
          end else begin
            passes <= passes + 1'b1;
            mv0    <= (c0 != '0);
            ex     <= edge_v;
            ey     <= edge_v;
            state  <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (md_done) begin
            if (mv0) begin x0 <= nx; y0 <= ny; end
            else begin x1 <= nx; y1 <= ny; end
            if (nc == '0 && point_count != 2'd2) begin
              if (point_count == 2'd0) begin first_x <= nx; first_y <= ny; end
              else begin second_x <= nx; second_y <= ny; end
              point_count <= point_count + 1'b1;
            end
            state <= S_DEC;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("result outside output state");
  assert property (@(posedge clk) disable iff (rst) passes <= 4'(PASS_LIMIT))
    else $error("pass count overrun");
  assert property (@(posedge clk) disable iff (rst) out_valid && !accepted
                   |-> point_count == 2'd0)
    else $error("rejected segment with points");
endmodule

/* sv/src_muldiv.sv */
// ----------------------------------------------------------------------------
// src_muldiv
// Shared interpolation unit: a0 + trunc(da*de/db), saturated. Multiply is
// shift-add one bit per cycle, divide is restoring, one bit per cycle.
// ----------------------------------------------------------------------------
module src_muldiv #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] a0,
  input  logic signed [W:0]   da,
  input  logic signed [W:0]   de,
  input  logic signed [W:0]   db,
  output logic                done,
  output logic signed [W-1:0] res
);
  localparam int PW = 2 * W + 2;
  localparam int CW = $clog2(PW + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] cnt;
  logic [W:0]    mcand;
  logic [W:0]    mplier;
  logic [PW-1:0] prod;
  logic [PW-1:0] quo;
  logic [W+1:0]  rem;
  logic [W:0]    dv;
  logic          neg;
  logic          dzero;
  logic signed [W-1:0] base;

  logic [W:0] abs_da, abs_de, abs_db;
  logic [W+1:0] rsh;
  logic [W+1:0] rsub;
  logic signed [PW:0] qs;
  logic signed [PW:0] sum;
  logic signed [PW:0] maxv, minv;

  assign abs_da = da[W] ? -da : da;
  assign abs_de = de[W] ? -de : de;
  assign abs_db = db[W] ? -db : db;
  assign rsh    = {rem[W:0], prod[PW-1]};
  assign rsub   = rsh - {1'b0, dv};
  assign qs     = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign sum    = qs + (PW + 1)'(base);
  assign maxv   = (PW + 1)'({1'b0, {(W - 1){1'b1}}});
  assign minv   = -maxv - 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            mcand  <= abs_da;
            mplier <= abs_de;
            dv     <= abs_db;
            dzero  <= (db == '0);
            neg    <= da[W] ^ de[W] ^ db[W];
            base   <= a0;
            prod   <= '0;
            cnt    <= CW'(W + 1);
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          prod   <= (prod << 1) + (mplier[W] ? PW'(mcand) : '0);
          mplier <= mplier << 1;
          cnt    <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            cnt   <= CW'(PW);
            rem   <= '0;
            quo   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          prod <= prod << 1;
          if (!rsub[W+1]) begin
            rem <= rsub;
            quo <= {quo[PW-2:0], 1'b1};
          end else begin
            rem <= rsh;
            quo <= {quo[PW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) state <= S_FIN;
        end
        S_FIN: begin
          if (dzero) res <= base;
          else if (sum > maxv) res <= maxv[W-1:0];
          else if (sum < minv) res <= minv[W-1:0];
          else res <= sum[W-1:0];
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == S_FIN)
    else $error("done without finish");
  assert property (@(posedge clk) disable iff (rst) state == S_DIV |-> cnt != '0)
    else $error("divide count underflow");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done pulse too long");
endmodule

/* tb/tb_segment_rectangle_clipper_core.sv */
// ----------------------------------------------------------------------------
// tb_segment_rectangle_clipper_core
// Self-checking bench for the Cohen-Sutherland segment clipper.
// ----------------------------------------------------------------------------
// Segments go in through a bursty sender, and results come out through a
// receiver that stalls on its own pattern. A scoreboard clips every accepted
// segment against its own copy of the rectangle and compares each result
// transfer field by field. The bench steps through several rectangles:
// reset, normal, full range, inverted, extreme and random.
// ----------------------------------------------------------------------------
module tb_segment_rectangle_clipper_core;
  timeunit 1ns;
  timeprecision 1ps;
  import src_pkg::*;

  localparam int CW = 32;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t x0, y0, x1, y1;
  } segment_t;
  typedef struct {
    logic [1:0] count;
    coord_t     fx, fy, sx, sy;
    logic       acc;
  } clip_result_t;

  class clip_scoreboard;
    clip_result_t pending_q[$];
    longint       min_x, max_x, min_y, max_y;
    int           errors;

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_edge(logic [1:0] idx, coord_t v);
      case (idx)
        REG_MIN_X: min_x = v;
        REG_MAX_X: max_x = v;
        REG_MIN_Y: min_y = v;
        REG_MAX_Y: max_y = v;
        default: ;
      endcase
    endfunction

    function logic [3:0] region(longint x, longint y);
      logic [3:0] c;
      c = '0;
      if (x < min_x) c |= OC_LEFT;
      else if (x > max_x) c |= OC_RIGHT;
      if (y < min_y) c |= OC_BOTTOM;
      else if (y > max_y) c |= OC_TOP;
      return c;
    endfunction

    // a0 + trunc((a1-a0)*(edge_v-b0)/(b1-b0)), saturated
    function longint edge_cross(longint a0, longint a1, longint b0, longint b1,
                                longint edge_v);
      logic signed [127:0] da, de, db, q, s;
      da = a1 - a0;
      de = edge_v - b0;
      db = b1 - b0;
      q  = (db == 0) ? 128'sd0 : (da * de) / db;
      s  = q + a0;
      if (s > CMAX) return CMAX;
      if (s < CMIN) return CMIN;
      return longint'(s);
    endfunction

    function clip_result_t clip(segment_t sg);
      clip_result_t r;
      longint x0, y0, x1, y1, x, y;
      logic [3:0] c0, c1, co;
      int n, passes;
      longint px[2], py[2];
      bit acc;
      x0 = sg.x0; y0 = sg.y0; x1 = sg.x1; y1 = sg.y1;
      c0 = region(x0, y0);
      c1 = region(x1, y1);
      n = 0; passes = 0; acc = 0;
      px = '{0, 0}; py = '{0, 0};
      forever begin
        if ((c0 | c1) == 0) begin
          acc = 1;
          break;
        end
        if ((c0 & c1) != 0) break;
        if (passes >= PASS_LIMIT) break;
        passes++;
        co = (c0 != 0) ? c0 : c1;
        if (co & OC_TOP) begin
          x = edge_cross(x0, x1, y0, y1, max_y); y = max_y;
        end else if (co & OC_BOTTOM) begin
          x = edge_cross(x0, x1, y0, y1, min_y); y = min_y;
        end else if (co & OC_RIGHT) begin
          y = edge_cross(y0, y1, x0, x1, max_x); x = max_x;
        end else begin
          y = edge_cross(y0, y1, x0, x1, min_x); x = min_x;
        end
        if (co == c0) begin
          x0 = x; y0 = y; c0 = region(x0, y0);
          if (c0 == 0 && n < 2) begin
            px[n] = x; py[n] = y; n++;
          end
        end else begin
          x1 = x; y1 = y; c1 = region(x1, y1);
          if (c1 == 0 && n < 2) begin
            px[n] = x; py[n] = y; n++;
          end
        end
      end
      if (!acc) begin
        n = 0;
        px = '{0, 0}; py = '{0, 0};
      end
      r.count = n[1:0];
      r.fx = px[0]; r.fy = py[0]; r.sx = px[1]; r.sy = py[1];
      r.acc = acc;
      return r;
    endfunction

    function void note_segment(segment_t sg);
      pending_q = {pending_q, clip(sg)};
    endfunction

    task check_result(clip_result_t got);
      clip_result_t exp_r;
      if (pending_q.size() == 0) begin
        report("result transfer with no segment outstanding");
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.count !== exp_r.count)
        report($sformatf("point_count %0d, expected %0d", got.count, exp_r.count));
      if (got.fx !== exp_r.fx)
        report($sformatf("first_x %0d, expected %0d", got.fx, exp_r.fx));
      if (got.fy !== exp_r.fy)
        report($sformatf("first_y %0d, expected %0d", got.fy, exp_r.fy));
      if (got.sx !== exp_r.sx)
        report($sformatf("second_x %0d, expected %0d", got.sx, exp_r.sx));
      if (got.sy !== exp_r.sy)
        report($sformatf("second_y %0d, expected %0d", got.sy, exp_r.sy));
      if (got.acc !== exp_r.acc)
        report($sformatf("accepted %0d, expected %0d", got.acc, exp_r.acc));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_MIN_X;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t seg_start_x = '0, seg_start_y = '0, seg_end_x = '0, seg_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] point_count;
  coord_t first_x, first_y, second_x, second_y;
  logic accepted;

  clip_scoreboard clip_sb;
  int hold_left = 0;

  always #6 clk = ~clk;

  segment_rectangle_clipper_core #(.COORD_WIDTH(CW), .FRAC_BITS(16)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
    .seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_count(point_count), .first_x(first_x), .first_y(first_y),
    .second_x(second_x), .second_y(second_y), .accepted(accepted)
  );

  // transfer monitor
  always @(posedge clk) begin
    clip_result_t got;
    if (!rst) begin
      if (in_valid && !in_stall)
        clip_sb.note_segment('{seg_start_x, seg_start_y, seg_end_x, seg_end_y});
      if (out_valid && !out_stall) begin
        got.count = point_count;
        got.fx = first_x; got.fy = first_y;
        got.sx = second_x; got.sy = second_y;
        got.acc = accepted;
        clip_sb.check_result(got);
      end
    end
  end

  // receiver stall pattern, with a single long hold-off
  initial begin
    int mode, left;
    mode = 0; left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task send_segment(segment_t sg);
    @(negedge clk);
    seg_start_x = sg.x0; seg_start_y = sg.y0;
    seg_end_x = sg.x1; seg_end_y = sg.y1;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task idle_input(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task wait_drained();
    while (clip_sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, coord_t v);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = v;
    clip_sb.set_edge(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task set_rect(coord_t mnx, coord_t mxx, coord_t mny, coord_t mxy);
    wait_drained();
    write_reg(REG_MIN_X, mnx);
    write_reg(REG_MAX_X, mxx);
    write_reg(REG_MIN_Y, mny);
    write_reg(REG_MAX_Y, mxy);
  endtask

  function coord_t clamp_coord(longint v);
    if (v > CMAX) return coord_t'(CMAX);
    if (v < CMIN) return coord_t'(CMIN);
    return coord_t'(v);
  endfunction

  function coord_t pick_coord(longint lo_e, longint hi_e);
    longint lo, hi, span;
    lo = (lo_e < hi_e) ? lo_e : hi_e;
    hi = (lo_e < hi_e) ? hi_e : lo_e;
    case ($urandom_range(0, 9))
      0, 1: return coord_t'($urandom);
      2: return ($urandom_range(0, 1)) ? coord_t'(lo_e) : coord_t'(hi_e);
      3: return ($urandom_range(0, 1)) ? coord_t'(CMAX) : coord_t'(CMIN);
      default: begin
        span = hi - lo + 64;
        lo = lo - span;
        span = 3 * span;
        return clamp_coord(lo + longint'({$urandom, $urandom} % longint'(span)));
      end
    endcase
  endfunction

  task random_burst(int count);
    segment_t sg;
    int burst;
    burst = 0;
    repeat (count) begin
      sg.x0 = pick_coord(clip_sb.min_x, clip_sb.max_x);
      sg.y0 = pick_coord(clip_sb.min_y, clip_sb.max_y);
      sg.x1 = pick_coord(clip_sb.min_x, clip_sb.max_x);
      sg.y1 = pick_coord(clip_sb.min_y, clip_sb.max_y);
      send_segment(sg);
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        idle_input($urandom_range(1, 40));
      end else begin
        burst--;
      end
    end
    idle_input(1);
  endtask

  localparam coord_t ONE = 32'sh0001_0000;
  localparam coord_t TEN = 32'sh000A_0000;

  initial begin
    segment_t directed[$];
    clip_sb = new();
    clip_sb.min_x = 0; clip_sb.max_x = 0; clip_sb.min_y = 0; clip_sb.max_y = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset rectangle: a single point at the origin
    directed = '{'{0, 0, 0, 0}, '{-ONE, -ONE, ONE, ONE}, '{-ONE, 0, ONE, 0},
                 '{coord_t'(CMIN), coord_t'(CMIN), coord_t'(CMAX), coord_t'(CMAX)}};
    foreach (directed[i]) send_segment(directed[i]);
    idle_input(1);

    set_rect(-TEN, TEN, -TEN, TEN);
    directed = '{
      '{0, 0, ONE, ONE},                         // both inside
      '{-2*TEN, 0, 2*TEN, 0},                    // crosses left and right
      '{0, -2*TEN, 0, 2*TEN},                    // crosses bottom and top
      '{0, 0, 3*TEN, ONE},                       // one crossing, start inside
      '{3*TEN, ONE, 0, 0},                       // one crossing, end inside
      '{-3*TEN, 2*TEN, 3*TEN, 2*TEN},            // above, rejected
      '{-3*TEN, 0, -2*TEN, ONE},                 // left, rejected
      '{-2*TEN, 0, 0, 2*TEN},                    // touches the corner
      '{-3*TEN, 5*ONE, 5*ONE, 3*TEN},            // misses the corner
      '{-TEN, -TEN, TEN, TEN},                   // on the corners
      '{coord_t'(CMIN), coord_t'(CMIN), coord_t'(CMAX), coord_t'(CMAX)},
      '{coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMIN), coord_t'(CMAX)},
      '{coord_t'(CMIN), 0, coord_t'(CMAX), ONE},
      '{-1, -1, 32'sh7FFF_FFFF, 32'sh8000_0000}
    };
    foreach (directed[i]) send_segment(directed[i]);
    idle_input(1);
    random_burst(120);

    // long receiver hold while the sender keeps offering
    hold_left = 1500;
    random_burst(30);

    // full range: everything is inside
    set_rect(coord_t'(CMIN), coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMAX));
    random_burst(60);

    // inverted rectangle: min above max on both axes
    set_rect(TEN, -TEN, ONE, -ONE);
    directed = '{'{0, 0, 0, 0}, '{-2*TEN, 0, 2*TEN, 0}, '{0, -2*TEN, 3, 2*TEN}};
    foreach (directed[i]) send_segment(directed[i]);
    idle_input(1);
    random_burst(120);

    // rectangle out at the extremes
    set_rect(coord_t'(CMAX - 5), coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMIN + 7));
    random_burst(100);

    // random rectangles, ordered and not
    repeat (4) begin
      set_rect(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
               coord_t'($urandom));
      random_burst(40);
      set_rect(-coord_t'($urandom_range(0, 1 << 22)), coord_t'($urandom_range(0, 1 << 22)),
               -coord_t'($urandom_range(0, 1 << 22)), coord_t'($urandom_range(0, 1 << 22)));
      random_burst(40);
    end

    while (clip_sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (clip_sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("TIMEOUT waiting for result transfers");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
